[rtl/core/p32exp_pkg.sv]
`timescale 1ns / 1ps
// Package for the posit32 (es = 2) exponential pipeline.
// Holds the special-case codes, the scaling and polynomial constants and the stage types.
// Depends on nothing.
package p32exp_pkg;

  localparam logic [31:0] P_ONE     = 32'h4000_0000;
  localparam logic [31:0] P_MAXPOS  = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MINPOS  = 32'h0000_0001;
  localparam logic [31:0] P_NAR     = 32'h8000_0000;
  localparam logic [31:0] SMALL_POS = 32'h0000_4000;
  localparam logic [31:0] SMALL_NEG = 32'hFFFF_BFFF;
  localparam logic [31:0] BIG_POS   = 32'h7FFF_FF00;
  localparam logic [31:0] BIG_NEG   = 32'h8000_0100;

  localparam logic [24:0] INV_LN2    = 25'h171_547A;
  localparam logic [63:0] FRAC37     = 64'h0000_001F_FFFF_FFFF;
  localparam logic [63:0] NEG_FRAC   = 64'h0000_0000_0FFF_FFFF;
  localparam logic [63:0] HIDDEN_29  = 64'h0000_0000_2000_0000;
  localparam logic [63:0] NEG_BIAS   = 64'h0100_0000_0000_0000;
  localparam logic [15:0] ROUND_BIAS = 16'h8000;

  localparam int HSTEPS = 10;

  typedef struct packed {
    logic        neg;
    logic        spec;
    logic [31:0] sval;
  } pre_t;

  typedef struct packed {
    logic        neg;
    logic        spec;
    logic [31:0] sval;
    logic [2:0]  fl;
    logic [36:0] t;
  } side_t;

  function automatic logic [63:0] hcoef(input logic [3:0] i);
    logic [63:0] c;
    unique case (i)
      4'd0:    c = 64'h1D8B7;
      4'd1:    c = 64'h50159;
      4'd2:    c = 64'h1713E4;
      4'd3:    c = 64'h400536;
      4'd4:    c = 64'h97D9B0;
      4'd5:    c = 64'h19DBC8;
      4'd6:    c = 64'h55548C;
      4'd7:    c = 64'hFFFDA;
      4'd8:    c = 64'h17FF80;
      4'd9:    c = 64'h40000;
      default: c = 64'h0;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] hshift(input logic [3:0] i);
    logic [5:0] s;
    unique case (i)
      4'd0:    s = 6'd32;
      4'd1:    s = 6'd26;
      4'd2:    s = 6'd28;
      4'd3:    s = 6'd24;
      4'd4:    s = 6'd22;
      4'd5:    s = 6'd18;
      4'd6:    s = 6'd17;
      4'd7:    s = 6'd14;
      4'd8:    s = 6'd11;
      4'd9:    s = 6'd10;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  // Length of the run of bits below bit 30 that equal bit 30.
  function automatic logic [4:0] run_len(input logic [30:0] x);
    logic [4:0] cnt;
    logic       stop;
    cnt  = 5'd0;
    stop = 1'b0;
    for (int j = 29; j >= 0; j--) begin
      if (!stop) begin
        if (x[j] == x[30]) begin
          cnt = cnt + 5'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return cnt;
  endfunction

endpackage

[rtl/core/p32exp_ifs.sv]
`timescale 1ns / 1ps
// Stream interfaces for the posit32 exponential: operand channel and result channel.
// Depends on nothing.
interface p32exp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] posit_in;
  modport source(output valid, output posit_in, input ready);
  modport sink(input valid, input posit_in, output ready);
endinterface

interface p32exp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] posit_out;
  modport source(output valid, output posit_out, input ready);
  modport sink(input valid, input posit_out, output ready);
endinterface

[rtl/core/posit32_exponential.sv]
`timescale 1ns / 1ps
// Exponential of a posit32 (es = 2) as a 26-stage pipeline.
// Depends on p32exp_pkg and the stream interfaces in p32exp_ifs.sv.
//
//   channel   direction  payload           handshake
//   operand   in         posit_in  [31:0]  valid / ready
//   result    out        posit_out [31:0]  valid / ready
//
// One item enters per cycle while no result waits to be taken.
// Most of the depth comes from ten polynomial steps, each a partial-product stage and a sum stage.
// Reset is synchronous and clears only the stage valid bits.
// When a result waits, every stage holds and operand.ready drops in the same cycle.
module posit32_exponential
  import p32exp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  p32exp_in_if.sink    operand,
  p32exp_out_if.source result
);

  logic adv;

  logic        s1_v;
  logic [30:0] s1_x;
  logic [4:0]  s1_k;
  pre_t        s1_side;

  logic              s2_v;
  logic signed [7:0] s2_sc;
  logic [26:0]       s2_fr;
  pre_t              s2_side;

  logic        s3_v;
  logic [63:0] s3_u;
  pre_t        s3_side;

  logic        s4_v;
  logic [56:0] s4_pp0;
  logic [31:0] s4_pp1;
  pre_t        s4_side;

  logic        s5_v;
  side_t       s5_side;

  logic        ha_v    [HSTEPS];
  side_t       ha_side [HSTEPS];
  logic [63:0] ha_p0   [HSTEPS];
  logic [31:0] ha_c1   [HSTEPS];
  logic [31:0] ha_c2   [HSTEPS];
  logic        hb_v    [HSTEPS];
  side_t       hb_side [HSTEPS];
  logic [63:0] hb_b    [HSTEPS];

  logic        st_v    [HSTEPS+1];
  side_t       st_side [HSTEPS+1];
  logic [63:0] st_b    [HSTEPS+1];

  logic        out_v;
  logic [31:0] out_data;
  logic        out_spec;
  logic        out_neg;

  assign adv              = !out_v || result.ready;
  assign operand.ready    = adv;
  assign result.valid     = out_v;
  assign result.posit_out = out_data;

  // Stage 1: special cases and regime run length.
  pre_t       c1_side;
  logic [31:0] x_in;
  assign x_in = operand.posit_in;

  always_comb begin
    c1_side.neg  = 1'b0;
    c1_side.spec = 1'b1;
    c1_side.sval = P_ONE;
    priority if (x_in < BIG_POS) begin
      c1_side.spec = (x_in < SMALL_POS);
    end else if (x_in > BIG_NEG) begin
      c1_side.neg  = 1'b1;
      c1_side.spec = (x_in > SMALL_NEG);
    end else if (x_in < P_NAR) begin
      c1_side.sval = P_MAXPOS;
    end else if (x_in > P_NAR) begin
      c1_side.sval = P_MINPOS;
    end else begin
      c1_side.sval = P_NAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x    <= x_in[30:0];
      s1_k    <= run_len(x_in[30:0]);
      s1_side <= c1_side;
    end
  end

  // Stage 2: exponent bits, fraction and scale.
  logic [28:0]       z2;
  logic signed [7:0] k2s;
  logic signed [7:0] e2s;
  logic signed [7:0] sc2;

  assign z2  = 29'(s1_x[28:0] << s1_k);
  assign k2s = $signed({2'b00, s1_k, 1'b0});
  assign e2s = $signed({6'b000000, z2[28:27]});

  always_comb begin
    if (!s1_side.neg) begin
      sc2 = s1_x[30] ? (8'sd30 + k2s + e2s) : (8'sd28 - k2s + e2s);
    end else begin
      sc2 = s1_x[30] ? (8'sd29 - k2s - e2s) : (8'sd31 + k2s - e2s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sc   <= sc2;
      s2_fr   <= z2[26:0];
      s2_side <= s1_side;
    end
  end

  // Stage 3: fixed-point argument ahead of the 1/ln2 scaling.
  logic [7:0]  nsc3;
  logic [7:0]  ksum3;
  logic [63:0] m3;
  logic [63:0] mn3;
  logic [63:0] u3;

  assign nsc3  = 8'(-s2_sc);
  assign ksum3 = 8'(8'sd27 + s2_sc);
  assign m3    = {36'b0, 1'b1, s2_fr};

  always_comb begin
    mn3 = 64'b0;
    u3  = 64'b0;
    if (!s2_side.neg) begin
      if (s2_sc < 8'sd0) begin
        u3 = m3 >> nsc3[5:0];
      end else if (s2_sc > 8'sd63) begin
        u3 = 64'b0;
      end else begin
        u3 = m3 << s2_sc[5:0];
      end
    end else begin
      if (s2_sc < 8'sd0) begin
        mn3 = (NEG_FRAC >> nsc3[5:0]) | (HIDDEN_29 - (64'd1 << ksum3[5:0]));
      end else if (s2_sc > 8'sd63) begin
        mn3 = 64'b0;
      end else begin
        mn3 = (NEG_FRAC << s2_sc[5:0]) & FRAC37;
      end
      u3 = HIDDEN_29 - mn3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_u    <= u3;
      s3_side <= s2_side;
    end
  end

  // Stage 4: partial products of the 1/ln2 scaling.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pp0  <= s3_u[31:0] * INV_LN2;
      s4_pp1  <= 32'(s3_u[63:32] * INV_LN2);
      s4_side <= s3_side;
    end
  end

  // Stage 5: integer and fractional parts of the scaled argument.
  logic [63:0] prod5;
  logic [63:0] q5;
  side_t       c5_side;

  assign prod5 = {7'b0, s4_pp0} + {s4_pp1, 32'b0};
  assign q5    = s4_side.neg ? (NEG_BIAS - prod5) : prod5;

  always_comb begin
    c5_side.neg  = s4_side.neg;
    c5_side.spec = s4_side.spec;
    c5_side.sval = s4_side.sval;
    c5_side.fl   = q5[63:61];
    c5_side.t    = q5[60:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side <= c5_side;
    end
  end

  assign st_v[0]    = s5_v;
  assign st_side[0] = s5_side;
  assign st_b[0]    = hcoef(4'd0);

  // Horner steps: partial products, then sum, shift and next coefficient (the last step adds a rounding bias).
  for (genvar i = 0; i < HSTEPS; i++) begin : g_horner
    logic [63:0] prod;
    logic [63:0] a;
    logic [63:0] b_next;

    always_ff @(posedge clk) begin
      if (rst) begin
        ha_v[i] <= 1'b0;
      end else if (adv) begin
        ha_v[i] <= st_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ha_side[i] <= st_side[i];
        ha_p0[i]   <= st_side[i].t[31:0] * st_b[i][31:0];
        ha_c1[i]   <= 32'(st_side[i].t[36:32] * st_b[i][31:0]);
        ha_c2[i]   <= 32'(st_side[i].t[31:0] * st_b[i][63:32]);
      end
    end

    assign prod = ha_p0[i] + {ha_c1[i] + ha_c2[i], 32'b0};
    assign a    = prod >> hshift(4'(i));

    if (i < HSTEPS - 1) begin : g_mid
      assign b_next = hcoef(4'(i + 1)) + a;
    end else begin : g_last
      assign b_next = a + 64'(ROUND_BIAS);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hb_v[i] <= 1'b0;
      end else if (adv) begin
        hb_v[i] <= ha_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hb_side[i] <= ha_side[i];
        hb_b[i]    <= b_next;
      end
    end

    assign st_v[i+1]    = hb_v[i];
    assign st_side[i+1] = hb_side[i];
    assign st_b[i+1]    = hb_b[i];
  end

  // Final stage: regime and exponent packing, round to nearest even.
  side_t       fs;
  logic [63:0] pf;
  logic [63:0] eb;
  logic [63:0] vf;
  logic [5:0]  sh;
  logic [63:0] rf;
  logic [63:0] low_mask;
  logic        guard;
  logic        sticky;
  logic        rnd;
  logic [31:0] res;

  assign fs = st_side[HSTEPS];
  assign pf = st_b[HSTEPS];
  assign eb = {14'b0, fs.fl[0], fs.fl[1], 48'b0};

  always_comb begin
    if (!fs.neg) begin
      vf = pf | eb | (fs.fl[2] ? 64'h0180_0000_0000_0000 : 64'h0080_0000_0000_0000);
      sh = fs.fl[2] ? 6'd38 : 6'd37;
    end else begin
      vf = pf | eb | 64'h0040_0000_0000_0000;
      sh = fs.fl[2] ? 6'd51 : 6'd52;
    end
  end

  assign rf       = vf >> sh;
  assign low_mask = (64'd1 << (sh - 6'd1)) - 64'd1;
  assign guard    = vf[sh - 6'd1];
  assign sticky   = |(vf & low_mask);
  assign rnd      = guard && (sticky || vf[sh]);
  assign res      = 32'(rf + {63'b0, rnd});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= st_v[HSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= fs.spec ? fs.sval : res;
      out_spec <= fs.spec;
      out_neg  <= fs.neg;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_spec && !out_neg |-> out_data[31:27] == 5'b0)
    else $error("positive-path result exceeds the packed field");

  a_neg_range: assert property (@(posedge clk) disable iff (rst)
    out_v && !out_spec && out_neg |-> out_data[31:6] == 26'b0)
    else $error("negative-path result exceeds the packed field");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(hb_b[HSTEPS-1]) && $stable(hb_v[HSTEPS-1]))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule
